[design/isc_pkg.sv]
package isc_pkg;

    localparam int ANGLE_INT_BITS_DEF   = 20;
    localparam int ANGLE_FRAC_BITS_DEF  = 43;
    localparam int RESULT_FRAC_BITS_DEF = 40;

    localparam int WF    = 60;
    localparam int TAB_N = 26;

    localparam logic [63:0] P2             = 64'd1 << WF;
    localparam logic [63:0] ONE_W          = P2;
    localparam logic [63:0] HALF_PI_W      = 64'h1921FB54442D1847;
    localparam logic [63:0] TWO_OVER_PI_22 = 64'd2670177;

    localparam logic [63:0] S3  = P2 / 64'd6;
    localparam logic [63:0] S5  = P2 / 64'd120;
    localparam logic [63:0] S7  = P2 / 64'd5040;
    localparam logic [63:0] S9  = P2 / 64'd362880;
    localparam logic [63:0] C2  = P2 / 64'd2;
    localparam logic [63:0] C4  = P2 / 64'd24;
    localparam logic [63:0] C6  = P2 / 64'd720;
    localparam logic [63:0] C8  = P2 / 64'd40320;
    localparam logic [63:0] C10 = P2 / 64'd3628800;

    typedef logic [63:0] rom_t [TAB_N];

    // Micro-operations of the shared multiplier, in program order.
    typedef enum logic [4:0] {
        OP_Q1, OP_Q2, OP_V,
        OP_S9, OP_S7, OP_S5, OP_S3, OP_S1,
        OP_C10, OP_C8, OP_C6, OP_C4, OP_C2,
        OP_SA, OP_SB, OP_CA, OP_CB
    } op_t;

    // Taylor series of sin(k/16) and cos(k/16), truncated step by step.
    function automatic logic [127:0] rom_entry(input logic [63:0] k);
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] c;
        t = P2;
        s = 64'd0;
        c = ONE_W;
        t = ((t / 64'd1) >> 4) * k;  s = s + t;
        t = ((t / 64'd2) >> 4) * k;  c = c - t;
        t = ((t / 64'd3) >> 4) * k;  s = s - t;
        t = ((t / 64'd4) >> 4) * k;  c = c + t;
        t = ((t / 64'd5) >> 4) * k;  s = s + t;
        t = ((t / 64'd6) >> 4) * k;  c = c - t;
        t = ((t / 64'd7) >> 4) * k;  s = s - t;
        t = ((t / 64'd8) >> 4) * k;  c = c + t;
        t = ((t / 64'd9) >> 4) * k;  s = s + t;
        t = ((t / 64'd10) >> 4) * k; c = c - t;
        t = ((t / 64'd11) >> 4) * k; s = s - t;
        t = ((t / 64'd12) >> 4) * k; c = c + t;
        t = ((t / 64'd13) >> 4) * k; s = s + t;
        t = ((t / 64'd14) >> 4) * k; c = c - t;
        t = ((t / 64'd15) >> 4) * k; s = s - t;
        t = ((t / 64'd16) >> 4) * k; c = c + t;
        t = ((t / 64'd17) >> 4) * k; s = s + t;
        t = ((t / 64'd18) >> 4) * k; c = c - t;
        t = ((t / 64'd19) >> 4) * k; s = s - t;
        t = ((t / 64'd20) >> 4) * k; c = c + t;
        t = ((t / 64'd21) >> 4) * k; s = s + t;
        t = ((t / 64'd22) >> 4) * k; c = c - t;
        t = ((t / 64'd23) >> 4) * k; s = s - t;
        t = ((t / 64'd24) >> 4) * k; c = c + t;
        t = ((t / 64'd25) >> 4) * k; s = s + t;
        t = ((t / 64'd26) >> 4) * k; c = c - t;
        t = ((t / 64'd27) >> 4) * k; s = s - t;
        t = ((t / 64'd28) >> 4) * k; c = c + t;
        t = ((t / 64'd29) >> 4) * k; s = s + t;
        t = ((t / 64'd30) >> 4) * k; c = c - t;
        return {s, c};
    endfunction

    function automatic rom_t build_rom(input logic want_cos);
        rom_t        rom;
        logic [127:0] e;
        for (int k = 0; k < TAB_N; k++)
        begin
            e = rom_entry(64'(k));
            rom[k] = want_cos ? e[63:0] : e[127:64];
        end
        return rom;
    endfunction

    localparam rom_t ROM_SIN = build_rom(1'b0);
    localparam rom_t ROM_COS = build_rom(1'b1);

endpackage

[design/isc_if.sv]
interface isc_in_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] angle_mid;
    logic [46:0]        angle_radius;

    modport source (output valid, angle_mid, angle_radius, input ready);
    modport sink   (input valid, angle_mid, angle_radius, output ready);
endinterface

interface isc_out_if #(
    parameter int RESULT_FRAC_BITS = isc_pkg::RESULT_FRAC_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [RESULT_FRAC_BITS+1:0] sine_mid;
    logic [RESULT_FRAC_BITS:0]          sine_radius;
    logic signed [RESULT_FRAC_BITS+1:0] cosine_mid;
    logic [RESULT_FRAC_BITS:0]          cosine_radius;
    logic                              too_wide;

    modport source (output valid, sine_mid, sine_radius, cosine_mid, cosine_radius,
                    too_wide, input ready);
    modport sink   (input valid, sine_mid, sine_radius, cosine_mid, cosine_radius,
                    too_wide, output ready);
endinterface

[design/interval_sine_cosine.sv]
// A wide transaction goes straight from acceptance to the output stage.
// Each endpoint runs 17 multiplications on one shared 32x32 multiplier, each with an issue step,
// four partial products and a write-back, plus four remainder correction steps.
// One transaction is in flight at a time, and its result is held while the output is busy;
// the next is taken while a result waits.
// Reset: rst_n is asynchronous and active low; it clears the sequencer and valids.
module interval_sine_cosine #(
    parameter int ANGLE_INT_BITS   = isc_pkg::ANGLE_INT_BITS_DEF,
    parameter int ANGLE_FRAC_BITS  = isc_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int RESULT_FRAC_BITS = isc_pkg::RESULT_FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    isc_in_if.sink     din,
    isc_out_if.source  dout
);
    import isc_pkg::*;

    localparam int EF  = ANGLE_FRAC_BITS - 1;
    localparam int MW  = ANGLE_INT_BITS + ANGLE_FRAC_BITS + 1;
    localparam int RW  = ANGLE_FRAC_BITS + 4;
    localparam int ESH = WF - EF;
    localparam int QSH = EF - 20;
    localparam int SH  = 61 - RESULT_FRAC_BITS;
    localparam int MB  = RESULT_FRAC_BITS + 2;
    localparam int RB  = RESULT_FRAC_BITS + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ISSUE = 6'b000010,
        S_MUL   = 6'b000100,
        S_WB    = 6'b001000,
        S_FIX   = 6'b010000,
        S_COMB  = 6'b100000
    } state_t;

    state_t       state_reg, state_next;
    op_t          op_reg, op_next;
    logic [1:0]   mcnt_reg, mcnt_next;
    logic [1:0]   fix_reg, fix_next;
    logic         ep_reg, ep_next;
    logic         wide_reg, wide_next;
    logic         ovalid_reg, ovalid_next;

    logic [63:0]  eb_reg, eb_next, e_reg, e_next;
    logic [63:0]  q_reg, q_next, r_reg, r_next, b_reg, b_next;
    logic [63:0]  v_reg, v_next, t_reg, t_next, bs_reg, bs_next, bc_reg, bc_next;
    logic [63:0]  as_reg, as_next, ac_reg, ac_next, s_reg, s_next;
    logic [63:0]  sa_reg, sa_next, ca_reg, ca_next, qa_reg, qa_next;
    logic [63:0]  sb_reg, sb_next, cb_reg, cb_next, qb_reg, qb_next;
    logic [63:0]  mx_reg, mx_next, my_reg, my_next;
    logic         neg_reg, neg_next;
    logic [127:0] acc_reg, acc_next;

    logic [MB-1:0] smid_reg, smid_next, cmid_reg, cmid_next;
    logic [RB-1:0] srad_reg, srad_next, crad_reg, crad_next;
    logic          otw_reg, otw_next;

    logic signed [63:0] mid_s;
    logic [63:0]  rr, mh, rh;
    logic [63:0]  opa, opb, mag, low, fr, res, rc, qc, rcl, cs_s, cs_c;
    logic [31:0]  xs, ys;
    logic [63:0]  prod;
    logic [127:0] pshift;
    logic [4:0]   idx;
    logic [63:0]  smin, smax, cmin, cmax, dq;
    logic [2:0]   dcnt;
    logic [1:0]   resid;
    logic [127:0] spk, cpk;
    logic         out_free;

    function automatic logic [127:0] pack(input logic [63:0] lo, input logic [63:0] hi);
        logic [63:0] bias;
        logic [63:0] biased;
        logic [63:0] m;
        logic [63:0] diff;
        logic [63:0] r;
        bias   = 64'd1 << 62;
        biased = hi + lo + bias;
        m      = (biased >> SH) - (bias >> SH);
        diff   = hi - lo;
        r      = (diff >> SH) + 64'(|diff[SH-1:0])
                 + (64'd1 << (RESULT_FRAC_BITS - 30)) + 64'(|biased[SH-1:0]);
        return {m, r};
    endfunction

    assign din.ready          = (state_reg == S_IDLE);
    assign dout.valid         = ovalid_reg;
    assign dout.sine_mid      = smid_reg;
    assign dout.sine_radius   = srad_reg;
    assign dout.cosine_mid    = cmid_reg;
    assign dout.cosine_radius = crad_reg;
    assign dout.too_wide      = otw_reg;
    assign out_free           = !ovalid_reg || dout.ready;

    // Endpoints at one fraction bit less, so that mid plus radius cannot overflow.
    assign mid_s = $signed(din.angle_mid[MW-1:0]);
    assign rr    = 64'(din.angle_radius[RW-1:0]);
    assign mh    = 64'(mid_s >>> 1);
    assign rh    = rr >> 1;

    always_comb
    begin
        mag = e_reg[63] ? (64'd0 - e_reg) : e_reg;
        opa = 64'd0;
        opb = v_reg;
        case (op_reg)
            OP_V:    begin opa = b_reg;           opb = b_reg; end
            OP_S9:   opa = S9;
            OP_S7:   opa = t_reg - S7;
            OP_S5:   opa = t_reg + S5;
            OP_S3:   opa = t_reg - S3;
            OP_S1:   begin opa = t_reg + ONE_W;   opb = b_reg; end
            OP_C10:  opa = 64'd0 - C10;
            OP_C8:   opa = t_reg + C8;
            OP_C6:   opa = t_reg - C6;
            OP_C4:   opa = t_reg + C4;
            OP_C2:   opa = t_reg - C2;
            OP_SA:   begin opa = as_reg;          opb = bc_reg; end
            OP_SB:   begin opa = ac_reg;          opb = bs_reg; end
            OP_CA:   begin opa = ac_reg;          opb = bc_reg; end
            OP_CB:   begin opa = as_reg;          opb = bs_reg; end
            default: begin opa = 64'd0;           opb = 64'd0;  end
        endcase
    end

    always_comb
    begin
        xs = mcnt_reg[1] ? mx_reg[63:32] : mx_reg[31:0];
        ys = mcnt_reg[0] ? my_reg[63:32] : my_reg[31:0];
        prod = xs * ys;
        case (mcnt_reg)
            2'd0:    pshift = {64'd0, prod};
            2'd3:    pshift = {prod, 64'd0};
            default: pshift = {32'd0, prod, 32'd0};
        endcase
        low = acc_reg[63:0];
        fr  = acc_reg[123:60];
        res = neg_reg ? (64'd0 - fr) : fr;
    end

    // One step of the quadrant correction, then the clamp and table lookup.
    always_comb
    begin
        rc = r_reg;
        qc = q_reg;
        if (r_reg[63])
        begin
            rc = r_reg + HALF_PI_W;
            qc = q_reg - 64'd1;
        end
        else if (r_reg >= HALF_PI_W)
        begin
            rc = r_reg - HALF_PI_W;
            qc = q_reg + 64'd1;
        end
        rcl = rc;
        if (rc[63])
            rcl = 64'd0;
        else if (rc >= HALF_PI_W)
            rcl = HALF_PI_W;
        idx = (rcl[63:56] > 8'(TAB_N - 1)) ? 5'(TAB_N - 1) : rcl[60:56];
    end

    // Quadrant swap of the current endpoint.
    always_comb
    begin
        case (q_reg[1:0])
            2'd0:    begin cs_s = s_reg;                    cs_c = t_reg - res; end
            2'd1:    begin cs_s = t_reg - res;              cs_c = 64'd0 - s_reg; end
            2'd2:    begin cs_s = 64'd0 - s_reg;            cs_c = res - t_reg; end
            default: begin cs_s = res - t_reg;              cs_c = s_reg; end
        endcase
    end

    always_comb
    begin
        smin = ($signed(sa_reg) < $signed(sb_reg)) ? sa_reg : sb_reg;
        smax = ($signed(sa_reg) < $signed(sb_reg)) ? sb_reg : sa_reg;
        cmin = ($signed(ca_reg) < $signed(cb_reg)) ? ca_reg : cb_reg;
        cmax = ($signed(ca_reg) < $signed(cb_reg)) ? cb_reg : ca_reg;
        dq   = qb_reg - qa_reg;
        if (dq[63])
            dcnt = 3'd0;
        else if (dq > 64'd4)
            dcnt = 3'd4;
        else
            dcnt = dq[2:0];
        // Each quadrant boundary crossed pins one bound to plus or minus one.
        for (int k = 0; k < 4; k++)
        begin
            resid = 2'(qa_reg[1:0] + 2'(k));
            if (3'(k) < dcnt)
            begin
                case (resid)
                    2'd1:    cmin = 64'd0 - ONE_W;
                    2'd3:    cmax = ONE_W;
                    2'd2:    smin = 64'd0 - ONE_W;
                    default: smax = ONE_W;
                endcase
            end
        end
        spk = pack(smin, smax);
        cpk = pack(cmin, cmax);
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        mcnt_next   = mcnt_reg;
        fix_next    = fix_reg;
        ep_next     = ep_reg;
        wide_next   = wide_reg;
        ovalid_next = ovalid_reg && !dout.ready;
        eb_next = eb_reg; e_next = e_reg;
        q_next  = q_reg;  r_next  = r_reg;  b_next = b_reg;
        v_next  = v_reg;  t_next  = t_reg;  bs_next = bs_reg; bc_next = bc_reg;
        as_next = as_reg; ac_next = ac_reg; s_next = s_reg;
        sa_next = sa_reg; ca_next = ca_reg; qa_next = qa_reg;
        sb_next = sb_reg; cb_next = cb_reg; qb_next = qb_reg;
        mx_next = mx_reg; my_next = my_reg; neg_next = neg_reg;
        acc_next  = acc_reg;
        smid_next = smid_reg; srad_next = srad_reg;
        cmid_next = cmid_reg; crad_next = crad_reg; otw_next = otw_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (din.valid)
                begin
                    wide_next = rr[ANGLE_FRAC_BITS+3];
                    eb_next   = mh + rh + 64'(mid_s[0] && rr[0]);
                    e_next    = mh - rh - 64'(!mid_s[0] && rr[0]);
                    ep_next   = 1'b0;
                    op_next   = OP_Q1;
                    state_next = rr[ANGLE_FRAC_BITS+3] ? S_COMB : S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                acc_next  = 128'd0;
                mcnt_next = 2'd0;
                state_next = S_MUL;
                if (op_reg == OP_Q1)
                begin
                    mx_next  = mag >> QSH;
                    my_next  = TWO_OVER_PI_22;
                    neg_next = 1'b0;
                end
                else if (op_reg == OP_Q2)
                begin
                    mx_next  = q_reg;
                    my_next  = HALF_PI_W;
                    neg_next = 1'b0;
                end
                else
                begin
                    mx_next  = opa[63] ? (64'd0 - opa) : opa;
                    my_next  = opb[63] ? (64'd0 - opb) : opb;
                    neg_next = opa[63] ^ opb[63];
                end
            end
            S_MUL:
            begin
                acc_next  = acc_reg + pshift;
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd3)
                    state_next = S_WB;
            end
            S_WB:
            begin
                state_next = S_ISSUE;
                op_next    = op_t'(op_reg + 5'd1);
                case (op_reg)
                    OP_Q1:
                        q_next = e_reg[63] ? ~{42'd0, low[63:42]} : {42'd0, low[63:42]};
                    OP_Q2:
                    begin
                        r_next     = (e_reg << ESH) - low;
                        fix_next   = 2'd0;
                        state_next = S_FIX;
                    end
                    OP_V:  v_next  = res;
                    OP_S1: bs_next = res;
                    OP_C2: bc_next = res + ONE_W;
                    OP_SB: s_next  = t_reg + res;
                    OP_CB:
                    begin
                        op_next = OP_Q1;
                        if (ep_reg)
                        begin
                            sb_next = cs_s; cb_next = cs_c; qb_next = q_reg;
                            state_next = S_COMB;
                        end
                        else
                        begin
                            sa_next = cs_s; ca_next = cs_c; qa_next = q_reg;
                            ep_next = 1'b1;
                            e_next  = eb_reg;
                        end
                    end
                    default: t_next = res;
                endcase
            end
            S_FIX:
            begin
                r_next   = rc;
                q_next   = qc;
                fix_next = fix_reg + 2'd1;
                if (fix_reg == 2'd3)
                begin
                    r_next  = rcl;
                    b_next  = rcl - {3'd0, idx, 56'd0};
                    as_next = ROM_SIN[idx];
                    ac_next = ROM_COS[idx];
                    op_next = OP_V;
                    state_next = S_ISSUE;
                end
            end
            S_COMB:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                    otw_next    = wide_reg;
                    if (wide_reg)
                    begin
                        smid_next = '0;
                        cmid_next = '0;
                        srad_next = RB'(64'd1 << RESULT_FRAC_BITS);
                        crad_next = RB'(64'd1 << RESULT_FRAC_BITS);
                    end
                    else
                    begin
                        smid_next = spk[64+MB-1:64];
                        srad_next = spk[RB-1:0];
                        cmid_next = cpk[64+MB-1:64];
                        crad_next = cpk[RB-1:0];
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_Q1;
            mcnt_reg   <= 2'd0;
            fix_reg    <= 2'd0;
            ep_reg     <= 1'b0;
            wide_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            mcnt_reg   <= mcnt_next;
            fix_reg    <= fix_next;
            ep_reg     <= ep_next;
            wide_reg   <= wide_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eb_reg <= eb_next; e_reg <= e_next;
        q_reg  <= q_next;  r_reg  <= r_next;  b_reg <= b_next;
        v_reg  <= v_next;  t_reg  <= t_next;  bs_reg <= bs_next; bc_reg <= bc_next;
        as_reg <= as_next; ac_reg <= ac_next; s_reg <= s_next;
        sa_reg <= sa_next; ca_reg <= ca_next; qa_reg <= qa_next;
        sb_reg <= sb_next; cb_reg <= cb_next; qb_reg <= qb_next;
        mx_reg <= mx_next; my_reg <= my_next; neg_reg <= neg_next;
        acc_reg  <= acc_next;
        smid_reg <= smid_next; srad_reg <= srad_next;
        cmid_reg <= cmid_next; crad_reg <= crad_next; otw_reg <= otw_next;
    end

`ifndef SYNTHESIS
    a_mcnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_MUL && state_reg != S_WB) |-> (mcnt_reg == 2'd0 || state_reg == S_ISSUE
            || state_reg == S_IDLE || state_reg == S_FIX || state_reg == S_COMB))
        else $error("multiplier step counter out of step");
    a_mul_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ISSUE) |=> (state_reg == S_MUL && mcnt_reg == 2'd0))
        else $error("multiplication did not start cleanly");
    a_wide_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && otw_reg) |-> (smid_reg == '0 && cmid_reg == '0))
        else $error("wide result with nonzero midpoint");
    a_rad_nz: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> (srad_reg != '0 && crad_reg != '0))
        else $error("radius lost its margin");
`endif

endmodule

[sim/tb_interval_sine_cosine.sv]
`timescale 1ns / 1ps

module tb_interval_sine_cosine;

    import isc_pkg::*;

    localparam int RFB = RESULT_FRAC_BITS_DEF;
    localparam int EFB = ANGLE_FRAC_BITS_DEF - 1;
    localparam int SH  = 61 - RFB;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int HOLD_CYCLES    = 600;
    localparam int RANDOM_ITEMS   = 1750;

    typedef struct packed {
        logic [63:0] mid;
        logic [46:0] radius;
    } angle_item_t;

    typedef struct packed {
        logic [RFB+1:0] s_mid;
        logic [RFB:0]   s_rad;
        logic [RFB+1:0] c_mid;
        logic [RFB:0]   c_rad;
        logic           wide;
    } enclosure_t;

    logic clk;
    logic rst_n;

    isc_in_if  din_if ();
    isc_out_if dout_if ();

    interval_sine_cosine i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    angle_item_t pending_angles[$];
    enclosure_t  expected_enclosures[$];
    logic [63:0] sin_step[TAB_N];
    logic [63:0] cos_step[TAB_N];
    int          errors;
    int          sent_count;
    int          result_count;
    int          wide_count;
    int          idle_cycles;
    int          hold_left;
    logic        hold_done;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Sine and cosine of k/16 by truncated Taylor terms.
    task automatic build_step_tables();
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] c;
        for (int k = 0; k < TAB_N; k++)
        begin
            t = P2;
            s = 64'd0;
            c = ONE_W;
            for (int n = 1; n <= 30; n++)
            begin
                t = ((t / 64'(n)) >> 4) * 64'(k);
                case (n % 4)
                    1: s = s + t;
                    2: c = c - t;
                    3: s = s - t;
                    default: c = c + t;
                endcase
            end
            sin_step[k] = s;
            cos_step[k] = c;
        end
    endtask

    // Q.60 product, magnitude truncated toward zero.
    function automatic logic [63:0] q60_mul(input logic [63:0] x, input logic [63:0] y);
        logic [63:0]  ux;
        logic [63:0]  uy;
        logic [127:0] prod;
        logic [63:0]  r;
        ux = x[63] ? -x : x;
        uy = y[63] ? -y : y;
        prod = {64'd0, ux} * {64'd0, uy};
        r = prod[123:60];
        return (x[63] ^ y[63]) ? -r : r;
    endfunction

    task automatic eval_endpoint(input logic signed [63:0] e, output logic signed [63:0] sn,
                                 output logic signed [63:0] cs, output logic signed [63:0] quad);
        logic [63:0]        mag;
        logic [63:0]        p;
        logic signed [63:0] q;
        logic [63:0]        r;
        logic [63:0]        b;
        logic [63:0]        v;
        logic [63:0]        bs;
        logic [63:0]        bc;
        logic [63:0]        s;
        logic [63:0]        c;
        int                 idx;
        mag = e[63] ? -e : e;
        p = ((mag >> (EFB - 20)) * TWO_OVER_PI_22) >> 42;
        q = e[63] ? -$signed(p) - 64'sd1 : $signed(p);
        r = (e << (WF - EFB)) - q * HALF_PI_W;
        for (int it = 0; it < 4; it++)
        begin
            if (r[63])
            begin
                q = q - 1;
                r = r + HALF_PI_W;
            end
            else if (r >= HALF_PI_W)
            begin
                q = q + 1;
                r = r - HALF_PI_W;
            end
        end
        if (r[63])
            r = 64'd0;
        if (r >= HALF_PI_W)
            r = HALF_PI_W;
        idx = int'(r >> 56);
        if (idx > TAB_N - 1)
            idx = TAB_N - 1;
        b = r - (64'(idx) << 56);
        v = q60_mul(b, b);
        bs = q60_mul(S9, v);
        bs = q60_mul(bs - S7, v);
        bs = q60_mul(bs + S5, v);
        bs = q60_mul(bs - S3, v);
        bs = q60_mul(bs + ONE_W, b);
        bc = q60_mul(-C10, v);
        bc = q60_mul(bc + C8, v);
        bc = q60_mul(bc - C6, v);
        bc = q60_mul(bc + C4, v);
        bc = q60_mul(bc - C2, v);
        bc = bc + ONE_W;
        s = q60_mul(sin_step[idx], bc) + q60_mul(cos_step[idx], bs);
        c = q60_mul(cos_step[idx], bc) - q60_mul(sin_step[idx], bs);
        case (q[1:0])
            2'd0: begin sn = s;  cs = c;  end
            2'd1: begin sn = c;  cs = -s; end
            2'd2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
        quad = q;
    endtask

    task automatic pack_bounds(input logic [63:0] lo, input logic [63:0] hi,
                               output logic [RFB+1:0] m, output logic [RFB:0] rad);
        logic [63:0] bias;
        logic [63:0] biased;
        logic [63:0] diff;
        logic [63:0] mask;
        logic [63:0] mm;
        logic [63:0] rr;
        bias = 64'd1 << 62;
        mask = (64'd1 << SH) - 64'd1;
        biased = hi + lo + bias;
        mm = (biased >> SH) - (bias >> SH);
        diff = hi - lo;
        rr = (diff >> SH) + 64'((diff & mask) != 0) + (64'd1 << (RFB - 30))
             + 64'((biased & mask) != 0);
        m = mm[RFB+1:0];
        rad = rr[RFB:0];
    endtask

    task automatic predict_enclosure(input angle_item_t a, output enclosure_t res);
        logic signed [63:0] mh;
        logic signed [63:0] rh;
        logic signed [63:0] ea;
        logic signed [63:0] eb;
        logic signed [63:0] sa, ca, sb, cb, qa, qb;
        logic signed [63:0] smin, smax, cmin, cmax, d, qt;
        if (a.radius >= (47'd8 << ANGLE_FRAC_BITS_DEF))
        begin
            res = '0;
            res.s_rad = {1'b1, {RFB{1'b0}}};
            res.c_rad = {1'b1, {RFB{1'b0}}};
            res.wide = 1'b1;
            return;
        end
        mh = $signed(a.mid) >>> 1;
        rh = $signed({18'd0, a.radius[46:1]});
        ea = mh - rh - ((a.mid[0] < a.radius[0]) ? 64'sd1 : 64'sd0);
        eb = mh + rh + ((a.mid[0] & a.radius[0]) ? 64'sd1 : 64'sd0);
        eval_endpoint(ea, sa, ca, qa);
        eval_endpoint(eb, sb, cb, qb);
        smin = sa < sb ? sa : sb;
        smax = sa < sb ? sb : sa;
        cmin = ca < cb ? ca : cb;
        cmax = ca < cb ? cb : ca;
        d = qb - qa;
        if (d < 0)
            d = 0;
        if (d > 4)
            d = 4;
        for (int t = 0; t < d; t++)
        begin
            qt = qa + t;
            case (qt[1:0])
                2'd1: cmin = -$signed(ONE_W);
                2'd3: cmax = $signed(ONE_W);
                2'd2: smin = -$signed(ONE_W);
                default: smax = $signed(ONE_W);
            endcase
        end
        pack_bounds(smin, smax, res.s_mid, res.s_rad);
        pack_bounds(cmin, cmax, res.c_mid, res.c_rad);
        res.wide = 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic angle_item_t random_angle();
        angle_item_t a;
        logic [63:0] k;
        int          kind;
        kind = $urandom_range(0, 99);
        a.radius = 47'(rand64() >> $urandom_range(17, 63));
        if (kind < 40)
            a.mid = {{17{1'b0}}, 47'(rand64())} - (64'd1 << 46);
        else if (kind < 55)
        begin
            // Near a multiple of pi/2 so that narrow intervals straddle a quadrant edge.
            k = 64'($urandom_range(0, 40)) - 64'd20;
            a.mid = k * (HALF_PI_W >> (WF - ANGLE_FRAC_BITS_DEF));
            a.mid = a.mid + 64'($urandom_range(0, 4000)) - 64'd2000;
            a.radius = 47'($urandom_range(0, 3000));
        end
        else if (kind < 65)
        begin
            a.mid = rand64();
            a.radius = 47'(rand64()) | (47'd8 << ANGLE_FRAC_BITS_DEF);
        end
        else if (kind < 85)
        begin
            a.mid = rand64();
            a.radius = a.radius & ~(47'd8 << ANGLE_FRAC_BITS_DEF);
        end
        else
        begin
            a.mid = rand64();
            a.radius = 47'(rand64());
        end
        return a;
    endfunction

    function automatic logic idle_now(input int count);
        if (count > 900 && count < 1200)
            return 1'b0;
        return $urandom_range(0, 99) < 12;
    endfunction

    // Source side: one assignment to valid per edge, so a held item is never re-raised.
    always @(posedge clk or negedge rst_n)
    begin
        enclosure_t  res;
        angle_item_t a;
        if (!rst_n)
        begin
            din_if.valid        <= 1'b0;
            din_if.angle_mid    <= '0;
            din_if.angle_radius <= '0;
        end
        else
        begin
            if (din_if.valid && din_if.ready)
            begin
                predict_enclosure({din_if.angle_mid, din_if.angle_radius}, res);
                expected_enclosures.push_back(res);
                sent_count <= sent_count + 1;
                if (res.wide)
                    wide_count <= wide_count + 1;
            end
            if (!din_if.valid || din_if.ready)
            begin
                if (pending_angles.size() != 0 && !idle_now(sent_count))
                begin
                    a = pending_angles.pop_front();
                    din_if.valid        <= 1'b1;
                    din_if.angle_mid    <= a.mid;
                    din_if.angle_radius <= a.radius;
                end
                else
                    din_if.valid <= 1'b0;
            end
        end
    end

    // Sink side, with one long hold-off while the source keeps offering.
    always @(posedge clk or negedge rst_n)
    begin
        enclosure_t exp_res;
        int         mismatches;
        if (!rst_n)
        begin
            dout_if.ready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else
        begin
            if (dout_if.valid && dout_if.ready)
            begin
                mismatches = 0;
                result_count <= result_count + 1;
                if (expected_enclosures.size() == 0)
                begin
                    $error("result with no transaction outstanding");
                    mismatches = mismatches + 1;
                end
                else
                begin
                    exp_res = expected_enclosures.pop_front();
                    if (dout_if.sine_mid !== exp_res.s_mid)
                    begin
                        $error("sine_mid expected %h actual %h", exp_res.s_mid, dout_if.sine_mid);
                        mismatches = mismatches + 1;
                    end
                    if (dout_if.sine_radius !== exp_res.s_rad)
                    begin
                        $error("sine_radius expected %h actual %h",
                               exp_res.s_rad, dout_if.sine_radius);
                        mismatches = mismatches + 1;
                    end
                    if (dout_if.cosine_mid !== exp_res.c_mid)
                    begin
                        $error("cosine_mid expected %h actual %h",
                               exp_res.c_mid, dout_if.cosine_mid);
                        mismatches = mismatches + 1;
                    end
                    if (dout_if.cosine_radius !== exp_res.c_rad)
                    begin
                        $error("cosine_radius expected %h actual %h",
                               exp_res.c_rad, dout_if.cosine_radius);
                        mismatches = mismatches + 1;
                    end
                    if (dout_if.too_wide !== exp_res.wide)
                    begin
                        $error("too_wide expected %b actual %b", exp_res.wide, dout_if.too_wide);
                        mismatches = mismatches + 1;
                    end
                end
                if (mismatches != 0)
                    errors <= errors + mismatches;
            end
            if (hold_left > 0)
            begin
                hold_left     <= hold_left - 1;
                dout_if.ready <= 1'b0;
            end
            else if (!hold_done && result_count == 400)
            begin
                hold_done     <= 1'b1;
                hold_left     <= HOLD_CYCLES;
                dout_if.ready <= 1'b0;
            end
            else
                dout_if.ready <= !idle_now(result_count);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no transaction for %0d cycles", idle_cycles);
            $display("FAIL interval_sine_cosine");
            $finish;
        end
    end

    task automatic add_angle(input logic [63:0] m, input logic [46:0] r);
        pending_angles.push_back('{mid: m, radius: r});
    endtask

    initial
    begin
        errors       = 0;
        sent_count   = 0;
        result_count = 0;
        wide_count   = 0;
        idle_cycles  = 0;
        rst_n        = 1'b0;
        build_step_tables();
        // Directed: zero, field extremes, wide threshold, quadrant edges, sign.
        add_angle(64'd0, 47'd0);
        add_angle(64'h7FFF_FFFF_FFFF_FFFF, 47'd0);
        add_angle(64'h8000_0000_0000_0000, 47'd0);
        add_angle(64'hFFFF_FFFF_FFFF_FFFF, 47'd1);
        add_angle(64'd1, 47'd1);
        add_angle(64'd0, 47'h7FFF_FFFF_FFFF);
        add_angle(64'd12345, 47'd8 << ANGLE_FRAC_BITS_DEF);
        add_angle(64'd12345, (47'd8 << ANGLE_FRAC_BITS_DEF) - 47'd1);
        add_angle(64'h7FFF_FFFF_FFFF_FFFF, (47'd8 << ANGLE_FRAC_BITS_DEF) - 47'd1);
        add_angle(64'h8000_0000_0000_0000, (47'd8 << ANGLE_FRAC_BITS_DEF) - 47'd1);
        add_angle(HALF_PI_W >> (WF - ANGLE_FRAC_BITS_DEF), 47'd0);
        add_angle(HALF_PI_W >> (WF - ANGLE_FRAC_BITS_DEF), 47'd16);
        add_angle(-(HALF_PI_W >> (WF - ANGLE_FRAC_BITS_DEF)), 47'd16);
        add_angle((HALF_PI_W * 2) >> (WF - ANGLE_FRAC_BITS_DEF), 47'd1 << 40);
        add_angle((HALF_PI_W * 3) >> (WF - ANGLE_FRAC_BITS_DEF), 47'd1 << 40);
        add_angle(64'd0, 47'd7 << ANGLE_FRAC_BITS_DEF);
        add_angle(64'd25 << (ANGLE_FRAC_BITS_DEF - 4), 47'd0);
        add_angle(64'd1 << ANGLE_FRAC_BITS_DEF, 47'd1 << ANGLE_FRAC_BITS_DEF);
        din_if.valid        = 1'b0;
        din_if.angle_mid    = '0;
        din_if.angle_radius = '0;
        dout_if.ready       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // The source stops here until every directed result has come back.
        wait (pending_angles.size() == 0 && !din_if.valid);
        wait (expected_enclosures.size() == 0);
        @(posedge clk);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            pending_angles.push_back(random_angle());
        wait (pending_angles.size() == 0 && !din_if.valid);
        wait (expected_enclosures.size() == 0);
        repeat (300) @(posedge clk);
        if (expected_enclosures.size() != 0)
        begin
            $error("%0d results never arrived", expected_enclosures.size());
            errors = errors + 1;
        end
        $display("Covered %0d angle intervals, %0d of them wide, %0d results checked,",
                 sent_count, wide_count, result_count);
        $display("including quadrant crossings, field extremes and a long output stall.");
        if (errors == 0)
            $display("PASS interval_sine_cosine");
        else
            $display("FAIL interval_sine_cosine");
        $finish;
    end

endmodule

[interval_sine_cosine.f]
design/isc_pkg.sv
design/isc_if.sv
design/interval_sine_cosine.sv
sim/tb_interval_sine_cosine.sv
